// ===== design/pwrc_pkg.sv =====
// Package for the pulse-width remote code decoder.
// Holds field widths, register indexes and the output payload type.
// No dependencies; imported by pwrc_match and pulse_width_remote_code_decoder.
package pwrc_pkg;

  localparam int DUR_W     = 24;  // signed duration field
  localparam int MARK_W    = 23;  // magnitude of a non-negative duration
  localparam int TIME_W    = 16;  // short_time / long_time
  localparam int PCT_W     = 7;   // tolerance_pct
  localparam int ABORT_W   = 4;   // abort_bits
  localparam int CODE_W    = 12;  // emitted code
  localparam int ADDR_W    = 8;   // address part of the code
  localparam int BUTTON_W  = 4;   // button part of the code
  localparam int PCT_SCALE = 100; // percent scale of the tolerance test

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_TIME    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_TIME     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE_PCT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ABORT_BITS    = 2'd3;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

// ===== design/pwrc_match.sv =====
// Tolerance window check of one duration magnitude against a nominal time.
// True when |mag - ref| * 100 <= ref * pct. Depends on pwrc_pkg.
module pwrc_match
  import pwrc_pkg::*;
(
  input  logic [DUR_W-1:0]  mag,
  input  logic [TIME_W-1:0] ref_time,
  input  logic [PCT_W-1:0]  pct,
  output logic              hit
);

  localparam int SCALE_W = 7;
  localparam int LHS_W   = DUR_W + SCALE_W;

  logic [DUR_W-1:0]          ref_ext;
  logic [DUR_W-1:0]          diff;
  logic [LHS_W-1:0]          lhs;
  logic [TIME_W+PCT_W-1:0]   rhs;

  assign ref_ext = DUR_W'(ref_time);
  assign diff    = (mag >= ref_ext) ? (mag - ref_ext) : (ref_ext - mag);
  // Constant scale: synthesis builds this from shifts and adds.
  assign lhs     = LHS_W'(diff) * LHS_W'(PCT_SCALE);
  assign rhs     = (TIME_W+PCT_W)'(ref_time) * (TIME_W+PCT_W)'(pct);
  assign hit     = (lhs <= LHS_W'(rhs));

endmodule

// ===== design/pulse_width_remote_code_decoder.sv =====
// Top level of the pulse-width remote code decoder.
// Depends on pwrc_pkg and pwrc_match (four window checks).
//
// Input stream: one signed duration per item in in_tdata; in_tuser marks
//   the first item of a capture, in_tlast its final item. Durations pair up
//   as mark and gap; short mark + long gap is a 0 bit, long mark + short gap
//   is a 1 bit, first bit most significant.
// Result stream: at most one item per input item. out_tuser is found; a
//   failed capture carries an all-zero out_tdata. Inputs after the end of a
//   capture produce nothing until the next first-of-capture item.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
//   (0 short_time, 1 long_time, 2 tolerance_pct, 3 abort_bits) at the edge.
// Timing: an accepted item is registered in the input stage, where the
//   pairing state and the window checks resolve it; its result then loads
//   the output register, which drives out_tvalid. One item per cycle is
//   sustained while the receiver does not stall. While the receiver stalls,
//   the output register holds its result; items that make no result still
//   pass, and a result-making item waits in the input stage with in_tready low.
// Reset: synchronous, active low; restores the default timing registers and
//   an empty capture, and clears both stages.
module pulse_width_remote_code_decoder
  import pwrc_pkg::*;
#(
  parameter int CODE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DUR_W-1:0]      in_tdata,   // [23:0] duration (signed)
  input  logic                  in_tuser,   // [0] first_of_capture
  input  logic                  in_tlast,   // last_of_capture
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [11:0] code, [19:12] address, [23:20] button
  output logic                  out_tuser   // [0] found
);

  localparam int TW = $clog2(CODE_BITS + 1);
  localparam int CW = (TW > ABORT_W) ? TW : ABORT_W;

  // Configuration registers
  logic [TIME_W-1:0]  short_time_r;
  logic [TIME_W-1:0]  long_time_r;
  logic [PCT_W-1:0]   tolerance_pct_r;
  logic [ABORT_W-1:0] abort_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_time_r    <= TIME_W'(430);
      long_time_r     <= TIME_W'(870);
      tolerance_pct_r <= PCT_W'(40);
      abort_bits_r    <= ABORT_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHORT_TIME:    short_time_r    <= cfg_wdata;
        REG_LONG_TIME:     long_time_r     <= cfg_wdata;
        REG_TOLERANCE_PCT: tolerance_pct_r <= cfg_wdata[PCT_W-1:0];
        REG_ABORT_BITS:    abort_bits_r    <= cfg_wdata[ABORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  logic             s1_v_r;
  logic [DUR_W-1:0] s1_dur_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             s1_emit;
  logic             s1_adv;

  // Capture state
  logic                 awaiting_gap_r, awaiting_gap_nxt;
  logic [MARK_W-1:0]    held_mark_r, held_mark_nxt;
  logic [CODE_BITS-1:0] bit_shift_r, bit_shift_nxt;
  logic [TW-1:0]        bit_tally_r, bit_tally_nxt;
  logic                 at_start_r, at_start_nxt;
  logic                 finished_r, finished_nxt;
  result_t              res_nxt;

  // Output register
  logic    out_v_r;
  result_t out_r;

  assign s1_adv    = s1_v_r && (!s1_emit || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_dur_r   <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // Window checks: held mark and current gap against both nominal times
  logic [DUR_W-1:0] mark_mag;
  logic [DUR_W-1:0] gap_mag;
  logic             dur_neg;
  logic             mark_short, mark_long, gap_short, gap_long;

  assign dur_neg  = s1_dur_r[DUR_W-1];
  assign mark_mag = DUR_W'(held_mark_r);
  assign gap_mag  = dur_neg ? (~s1_dur_r + DUR_W'(1)) : s1_dur_r;

  pwrc_match u_mark_short (.mag(mark_mag), .ref_time(short_time_r),
                           .pct(tolerance_pct_r), .hit(mark_short));
  pwrc_match u_mark_long  (.mag(mark_mag), .ref_time(long_time_r),
                           .pct(tolerance_pct_r), .hit(mark_long));
  pwrc_match u_gap_short  (.mag(gap_mag), .ref_time(short_time_r),
                           .pct(tolerance_pct_r), .hit(gap_short));
  pwrc_match u_gap_long   (.mag(gap_mag), .ref_time(long_time_r),
                           .pct(tolerance_pct_r), .hit(gap_long));

  logic                  is_zero, is_one;
  logic [CODE_BITS-1:0]  shift_in;
  logic [TW-1:0]         tally_in;
  logic [TW-1:0]         tally_inc;
  logic [CODE_BITS+CODE_W-1:0] shift_ext;

  assign is_zero = mark_short && gap_long;   // 0 pattern wins when both match
  assign is_one  = mark_long && gap_short;

  // Pairing step for the item in the input stage
  always_comb begin
    // A first-of-capture item clears the capture before it is handled
    awaiting_gap_nxt = s1_first_r ? 1'b0 : awaiting_gap_r;
    held_mark_nxt    = held_mark_r;
    shift_in         = s1_first_r ? '0 : bit_shift_r;
    tally_in         = s1_first_r ? '0 : bit_tally_r;
    at_start_nxt     = s1_first_r ? 1'b1 : at_start_r;
    finished_nxt     = s1_first_r ? 1'b0 : finished_r;
    bit_shift_nxt    = shift_in;
    bit_tally_nxt    = tally_in;
    tally_inc        = tally_in + TW'(1);
    s1_emit          = 1'b0;
    res_nxt.found    = 1'b0;
    res_nxt.code     = '0;
    shift_ext        = '0;

    if (!finished_nxt) begin
      at_start_nxt = 1'b0;
      if (!awaiting_gap_nxt) begin
        if (dur_neg) begin
          // Drop a low level at the start; anywhere else it fails the capture
          if (!(s1_first_r || at_start_r)) begin
            s1_emit = 1'b1;
          end
        end else begin
          held_mark_nxt    = s1_dur_r[MARK_W-1:0];
          awaiting_gap_nxt = 1'b1;
        end
      end else begin
        awaiting_gap_nxt = 1'b0;
        if (!is_zero && !is_one) begin
          if (CW'(tally_in) >= CW'(abort_bits_r)) begin
            s1_emit = 1'b1;
          end else begin
            bit_shift_nxt = '0;
            bit_tally_nxt = '0;
          end
        end else begin
          bit_shift_nxt = {shift_in[CODE_BITS-2:0], is_one && !is_zero};
          bit_tally_nxt = tally_inc;
          if (tally_inc >= TW'(CODE_BITS)) begin
            s1_emit       = 1'b1;
            res_nxt.found = 1'b1;
            shift_ext     = (CODE_BITS+CODE_W)'(bit_shift_nxt);
            res_nxt.code  = shift_ext[CODE_W-1:0];
          end
        end
      end
      // Capture ended without a code
      if (!s1_emit && s1_last_r) begin
        s1_emit = 1'b1;
      end
      if (s1_emit) begin
        finished_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_gap_r <= 1'b0;
      held_mark_r    <= '0;
      bit_shift_r    <= '0;
      bit_tally_r    <= '0;
      at_start_r     <= 1'b1;
      finished_r     <= 1'b0;
    end else if (s1_adv) begin
      awaiting_gap_r <= awaiting_gap_nxt;
      held_mark_r    <= held_mark_nxt;
      bit_shift_r    <= bit_shift_nxt;
      bit_tally_r    <= bit_tally_nxt;
      at_start_r     <= at_start_nxt;
      finished_r     <= finished_nxt;
    end
  end

  // Output register: load a result, hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.found;
  assign out_tdata  = {out_r.code[BUTTON_W-1:0],
                       out_r.code[CODE_W-1:BUTTON_W],
                       out_r.code};

  // Checks on the decoder's own logic
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed capture carries nonzero payload");

  a_quiet_item_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_emit |-> s1_adv)
    else $error("item without result blocked in input stage");

  a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_emit |=> finished_r && out_v_r)
    else $error("emitted result did not end the capture");

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_tally_r <= TW'(CODE_BITS))
    else $error("bit tally beyond code length");

endmodule

// ===== bench/tb_pulse_width_remote_code_decoder.sv =====
// Self-checking bench for the pulse-width remote code decoder.
// Drives remote captures through the input stream and checks every code or
// not-found item against a built-in decoder. Depends on design/pwrc_pkg.sv.
module tb_pulse_width_remote_code_decoder
  import pwrc_pkg::*;
();

  localparam int CODE_BITS_N = 12;
  localparam int WATCHDOG_LIMIT = 4000; // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 6;     // input stage plus output register, with margin
  localparam int LONG_HOLD = 300;       // receiver hold-off used to back up the block
  localparam int PHASE_ITEMS = 225;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             first;
    logic             last;
  } dur_item_t;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } code_rec_t;

  // Clock, reset and block ports; every input has a known value from time 0.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DUR_W-1:0]      in_tdata = '0;   // [23:0] duration (signed)
  logic                  in_tuser = 1'b0; // [0] first_of_capture
  logic                  in_tlast = 1'b0; // last_of_capture
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // [11:0] code, [19:12] address, [23:20] button
  logic                  out_tuser;       // [0] found

  // Stimulus queue, expected results and run bookkeeping.
  dur_item_t pending_durations[$];
  code_rec_t expected_codes[$];
  int        items_made = 0;
  int        err_count = 0;
  int        idle_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;

  // Decoder copy: timing registers and capture state, as after reset.
  int                short_nom = 430;
  int                long_nom = 870;
  int                tol_pct = 40;
  int                abort_at = 8;
  bit                pend_gap = 1'b0;
  longint            mark_hold = 0;
  logic [CODE_W-1:0] bits_in = '0;
  int                bits_held = 0;
  bit                cap_start = 1'b1;
  bit                cap_done = 1'b0;

  pulse_width_remote_code_decoder #(
    .CODE_BITS(CODE_BITS_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic log_mismatch(input string what, input longint got, input longint want);
    if (err_count < 50) begin
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
    err_count++;
  endtask

  // Window test: |mag - nominal| * 100 <= nominal * tolerance, exact in 64 bits.
  function automatic bit in_window(input longint mag, input longint nominal);
    longint diff;
    diff = (mag >= nominal) ? mag - nominal : nominal - mag;
    return diff * PCT_SCALE <= nominal * tol_pct;
  endfunction

  // Close the capture with one result; a failed capture carries a zero code.
  task automatic close_capture(input bit found, input logic [CODE_W-1:0] code);
    code_rec_t rec;
    rec.found = found;
    rec.code = found ? code : '0;
    expected_codes.push_back(rec);
    cap_done = 1'b1;
  endtask

  // Advance the decoder copy by one accepted duration.
  task automatic decode_duration(input logic [DUR_W-1:0] dur, input bit first,
                                 input bit last);
    longint d;
    longint gap_mag;
    bit     was_start;
    int     bit_val;
    d = $signed(dur);
    if (first) begin
      pend_gap = 1'b0;
      mark_hold = 0;
      bits_in = '0;
      bits_held = 0;
      cap_start = 1'b1;
      cap_done = 1'b0;
    end
    if (cap_done) return;
    was_start = cap_start;
    cap_start = 1'b0;
    if (!pend_gap) begin
      if (d < 0) begin
        // A low level leading the capture is dropped; anywhere else it fails.
        if (!was_start) begin
          close_capture(1'b0, '0);
          return;
        end
      end else begin
        mark_hold = d;
        pend_gap = 1'b1;
      end
    end else begin
      gap_mag = (d < 0) ? -d : d;
      pend_gap = 1'b0;
      bit_val = -1;
      // The 0-bit pattern wins when both patterns match.
      if (in_window(mark_hold, short_nom) && in_window(gap_mag, long_nom)) begin
        bit_val = 0;
      end else if (in_window(mark_hold, long_nom) && in_window(gap_mag, short_nom)) begin
        bit_val = 1;
      end
      if (bit_val < 0) begin
        if (bits_held >= abort_at) begin
          close_capture(1'b0, '0);
          return;
        end
        bits_in = '0;
        bits_held = 0;
      end else begin
        bits_in = {bits_in[CODE_W-2:0], bit_val[0]};
        bits_held++;
        if (bits_held >= CODE_BITS_N) begin
          close_capture(1'b1, bits_in);
          return;
        end
      end
    end
    if (last) close_capture(1'b0, '0);
  endtask

  // Driver: hold an offered item until taken, then pick the next or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_duration(in_tdata, in_tuser, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_durations.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          dur_item_t nxt;
          nxt = pending_durations.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.dur;
          in_tuser <= nxt.first;
          in_tlast <= nxt.last;
        end else begin
          // Idle: drop valid and scramble the payload so stray samples show up.
          in_tvalid <= 1'b0;
          in_tdata <= DUR_W'($urandom);
          in_tuser <= 1'($urandom_range(0, 1));
          in_tlast <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Monitor and receiver: check each taken result, then decide ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          log_mismatch("result with nothing pending", out_tdata, 0);
        end else begin
          code_rec_t want;
          want = expected_codes.pop_front();
          if (out_tuser !== want.found) log_mismatch("found", out_tuser, want.found);
          if (out_tdata[CODE_W-1:0] !== want.code) begin
            log_mismatch("code", out_tdata[CODE_W-1:0], want.code);
          end
          if (out_tdata[CODE_W+ADDR_W-1:CODE_W] !== want.code[CODE_W-1:BUTTON_W]) begin
            log_mismatch("address", out_tdata[CODE_W+ADDR_W-1:CODE_W],
                         want.code[CODE_W-1:BUTTON_W]);
          end
          if (out_tdata[CODE_W+ADDR_W+BUTTON_W-1:CODE_W+ADDR_W] !==
              want.code[BUTTON_W-1:0]) begin
            log_mismatch("button", out_tdata[CODE_W+ADDR_W+BUTTON_W-1:CODE_W+ADDR_W],
                         want.code[BUTTON_W-1:0]);
          end
        end
      end
      // Count the long hold-off down here; otherwise stall at the phase rate.
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic void push_item(input int d, input bit first, input bit last);
    dur_item_t it;
    it.dur = d[DUR_W-1:0];
    it.first = first;
    it.last = last;
    pending_durations.push_back(it);
    items_made++;
  endfunction

  // Duration inside the window of a nominal value, sometimes right on its edge.
  function automatic int near_val(input int nominal);
    int dev_max;
    int dev;
    dev_max = nominal * tol_pct / PCT_SCALE;
    dev = ($urandom_range(0, 7) == 0) ? dev_max : int'($urandom_range(0, dev_max));
    return $urandom_range(0, 1) ? nominal + dev : nominal - dev;
  endfunction

  // Duration just or far outside the window.
  function automatic int miss_val(input int nominal);
    int dev;
    dev = nominal * tol_pct / PCT_SCALE + 1;
    if ($urandom_range(0, 1)) dev += $urandom_range(0, nominal + 100);
    if ($urandom_range(0, 1) && nominal - dev >= 0) return nominal - dev;
    return nominal + dev;
  endfunction

  // Gaps are mostly low levels, so send most of them negative.
  function automatic int as_gap(input int mag);
    return ($urandom_range(0, 9) < 7) ? -mag : mag;
  endfunction

  // Queue one capture: mostly a clean code, sometimes broken on purpose.
  task automatic queue_capture();
    int seq[$];
    int shape;
    int cut;
    int k;
    int b;
    bit with_last;
    shape = $urandom_range(0, 9);
    cut = $urandom_range(0, CODE_BITS_N - 1);
    with_last = ($urandom_range(0, 7) != 0);
    // Leading low level, which the decoder drops before pairing.
    if ($urandom_range(0, 3) == 0) seq.push_back(-int'($urandom_range(1, 3000)));
    // Junk pairs ahead of the code make the decoder restart, or fail at abort_bits 0.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        seq.push_back(miss_val(short_nom));
        seq.push_back(as_gap(miss_val(long_nom)));
      end
    end
    for (k = 0; k < CODE_BITS_N; k++) begin
      if (k == cut && shape == 6) begin
        seq.push_back(miss_val(short_nom));
        seq.push_back(as_gap(near_val(long_nom)));
      end else if (k == cut && shape == 7) begin
        seq.push_back(-int'($urandom_range(1, 5000)));
      end else if (k == cut && shape == 8) begin
        break;
      end
      b = $urandom_range(0, 1);
      seq.push_back(near_val(b ? long_nom : short_nom));
      seq.push_back(as_gap(near_val(b ? short_nom : long_nom)));
    end
    // Truncated capture, possibly with a trailing mark that has no gap.
    if (shape == 8 && $urandom_range(0, 1)) seq.push_back(near_val(short_nom));
    // Items after the end of the capture must be ignored.
    if (shape == 9) repeat ($urandom_range(1, 4)) seq.push_back($urandom);
    for (k = 0; k < seq.size(); k++) begin
      push_item(seq[k], k == 0, with_last && k == seq.size() - 1);
    end
  endtask

  // Wait at falling edges until the block has nothing left to deliver.
  task automatic drain();
    while (pending_durations.size() != 0 || in_tvalid || expected_codes.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_SHORT_TIME:    short_nom = val & 16'hFFFF;
      REG_LONG_TIME:     long_nom = val & 16'hFFFF;
      REG_TOLERANCE_PCT: tol_pct = val & 7'h7F;
      REG_ABORT_BITS:    abort_at = val & 4'hF;
      default: ;
    endcase
  endtask

  // One phase: reconfigure while idle, set the idle rates, then load items.
  task automatic run_phase(input int s_time, input int l_time, input int pct,
                           input int abort_n, input int send_pct, input int recv_pct,
                           input bit long_hold);
    int start;
    drain();
    write_reg(REG_SHORT_TIME, s_time);
    write_reg(REG_LONG_TIME, l_time);
    write_reg(REG_TOLERANCE_PCT, pct);
    write_reg(REG_ABORT_BITS, abort_n);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = items_made;
    while (items_made - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: full-range durations with random capture marks.
        repeat ($urandom_range(1, 5)) begin
          push_item($urandom, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
      end else begin
        queue_capture();
      end
    end
    // Back up the block: the receiver holds off while the sender keeps going.
    if (long_hold) hold_left = LONG_HOLD;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed captures at the reset timing (430 / 870 / 40% / abort 8).
    push_item(-8388608, 1'b1, 1'b0); // leading low level, dropped
    push_item(8388607, 1'b0, 1'b0);  // widest mark
    push_item(0, 1'b0, 1'b0);        // zero gap: bad pair, bits restart
    push_item(430, 1'b0, 1'b0);
    push_item(-870, 1'b0, 1'b0);     // negative gap: 0 bit
    push_item(870, 1'b0, 1'b0);
    push_item(430, 1'b0, 1'b0);      // positive gap: 1 bit
    push_item(-5, 1'b0, 1'b0);       // low level in mark position: fails
    push_item(600, 1'b0, 1'b1);      // after the end: ignored
    push_item(430, 1'b1, 1'b0);
    push_item(-870, 1'b0, 1'b0);
    push_item(870, 1'b0, 1'b1);      // trailing mark: not-found
    push_item(602, 1'b1, 1'b0);      // on the window edge
    push_item(-1218, 1'b0, 1'b0);    // on the window edge
    push_item(603, 1'b0, 1'b0);      // one past the edge
    push_item(870, 1'b0, 1'b1);
    push_item(100, 1'b1, 1'b1);      // lone mark that is also last
    push_item(-100, 1'b1, 1'b1);     // lone leading low level that is also last

    // Timing settings, extremes first, under a mix of idle patterns.
    run_phase(430, 870, 40, 8, 0, 0, 1'b1);
    run_phase(1, 65535, 100, 12, 72, 0, 1'b0);
    run_phase(65535, 1, 0, 0, 0, 72, 1'b0);
    run_phase(500, 500, 30, 4, 10, 10, 1'b0);   // both patterns match
    run_phase(0, 300, 50, 6, 0, 0, 1'b0);       // zero short reference
    run_phase(300, 900, 25, 2, 72, 0, 1'b0);
    run_phase($urandom_range(20, 5000), $urandom_range(20, 5000), $urandom_range(0, 100),
              $urandom_range(0, 12), 0, 72, 1'b0);
    run_phase($urandom_range(20, 5000), $urandom_range(20, 5000), $urandom_range(0, 100),
              $urandom_range(0, 12), 10, 10, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
